// File: sv/rcwc_pkg.sv
// Shared types, constants and a helper function for the Reno congestion window control.
package rcwc_pkg;

  localparam int SEQ_BITS   = 16;
  localparam int WIN_BITS   = 6;
  localparam int MAX_WINDOW = 32;

  typedef logic [SEQ_BITS-1:0] seq_t;
  typedef logic [SEQ_BITS:0]   ackpt_t;
  typedef logic [WIN_BITS-1:0] win_t;

  localparam win_t WIN_MAX        = win_t'(MAX_WINDOW);
  localparam win_t SSTHRESH_RESET = (8 > MAX_WINDOW) ? win_t'(MAX_WINDOW) : win_t'(8);

  // Input item function codes.
  localparam logic [1:0] FN_START   = 2'd0;
  localparam logic [1:0] FN_ACK     = 2'd1;
  localparam logic [1:0] FN_TIMEOUT = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_NEW  = 2'd0;
  localparam logic [1:0] KIND_RETX = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  // Congestion control phases.
  localparam logic [1:0] MODE_SS = 2'd0;
  localparam logic [1:0] MODE_CA = 2'd1;
  localparam logic [1:0] MODE_FR = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    seq_t       ack_seq;
    seq_t       seg_count;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    seq_t       send_seq;
    win_t       window;
    logic [1:0] mode;
    logic       last;
  } res_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic emit_last;
  } status_t;

  // Window growth by one, saturating at the window limit.
  function automatic win_t grow(input win_t w);
    logic [WIN_BITS:0] w1;
    w1 = {1'b0, w} + 1'b1;
    grow = (w1 >= (WIN_BITS+1)'(MAX_WINDOW)) ? WIN_MAX : w1[WIN_BITS-1:0];
  endfunction

endpackage

// File: sv/rcwc_ctrl.sv
// Controller state machine: sequences accept, state update and result emission.
module rcwc_ctrl import rcwc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_SEND
  } state_e;

  state_e state_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = (state_q == S_IDLE) && in_valid_i;
    cmd_o.update = (state_q == S_UPDATE);
    cmd_o.emit   = (state_q == S_SEND) && st_i.out_free;
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_UPDATE;
        end
        S_UPDATE: begin
          state_q <= S_SEND;
        end
        S_SEND: begin
          if (st_i.out_free && st_i.emit_last) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/rcwc_dpath.sv
// Datapath: congestion state registers, step update logic, burst generation and result register.
module rcwc_dpath import rcwc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   in_data_i,
  input  logic    cfg_we_i,
  input  win_t    cfg_wdata_i,
  input  cmd_t    cmd_i,
  output status_t st_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output res_t    out_data_o
);

  item_t      item_q;
  win_t       init_ss_q;
  logic [1:0] phase_q, phase_d;
  win_t       cwnd_q, cwnd_d;
  win_t       ss_q, ss_d;
  logic [1:0] dup_q, dup_d;
  win_t       in_flight_q, in_flight_d;
  ackpt_t     last_acked_q, last_acked_d;
  seq_t       last_sent_q, last_sent_d;
  seq_t       acked_q, acked_d;
  seq_t       total_q, total_d;
  win_t       credit_q, credit_d;
  logic       active_q, active_d;

  // Pending work for the emission phase of the current item.
  logic       first_pend_q, first_pend_d;
  logic [1:0] first_kind_q, first_kind_d;
  seq_t       first_seq_q, first_seq_d;
  logic       burst_en_q, burst_en_d;
  logic       end_pend_q, end_pend_d;

  logic       out_valid_q;
  res_t       out_q;
  res_t       res_now;

  ackpt_t            a_ext, tot_ext, a_clip, a_plus, next_exp, diff;
  seq_t              acked_new;
  win_t              grown, half, ss_new, credit_n;
  logic [1:0]        dup_n;
  logic [WIN_BITS:0] ss_plus3;
  ackpt_t            ls_p1;
  logic [SEQ_BITS+1:0] ls_p2;
  logic [WIN_BITS:0] inf_p1;
  logic              burst_ok, next_ok;

  always_comb begin
    a_ext     = {1'b0, item_q.ack_seq};
    tot_ext   = {1'b0, total_q};
    a_clip    = (a_ext >= tot_ext) ? (tot_ext - 1'b1) : a_ext;
    a_plus    = a_clip + 1'b1;
    next_exp  = last_acked_q + 1'b1;
    diff      = a_plus - next_exp;
    acked_new = acked_q + diff[SEQ_BITS-1:0];
    grown     = grow(cwnd_q);
    half      = cwnd_q >> 1;
    ss_plus3  = {1'b0, half} + (WIN_BITS+1)'(3);
    ss_new    = (init_ss_q > WIN_MAX) ? WIN_MAX : init_ss_q;
    credit_n  = credit_q + 1'b1;
    dup_n     = (dup_q == 2'd3) ? dup_q : dup_q + 1'b1;

    ls_p1    = {1'b0, last_sent_q} + 1'b1;
    ls_p2    = {2'b00, last_sent_q} + (SEQ_BITS+2)'(2);
    inf_p1   = {1'b0, in_flight_q} + 1'b1;
    burst_ok = burst_en_q && (in_flight_q < cwnd_q) && (ls_p1 < tot_ext);
    next_ok  = (inf_p1 < {1'b0, cwnd_q}) && (ls_p2 < {1'b0, tot_ext});
  end

  // Result offered for the next emission; window and mode are already final.
  always_comb begin
    res_now        = '0;
    res_now.window = cwnd_q;
    res_now.mode   = phase_q;
    if (first_pend_q) begin
      res_now.kind     = first_kind_q;
      res_now.send_seq = first_seq_q;
      res_now.last     = 1'b1;
    end else if (burst_ok) begin
      res_now.kind     = KIND_NEW;
      res_now.send_seq = ls_p1[SEQ_BITS-1:0];
      res_now.last     = !next_ok && !end_pend_q;
    end else if (end_pend_q) begin
      res_now.kind = KIND_END;
      res_now.last = 1'b1;
    end else begin
      res_now.kind = KIND_NONE;
      res_now.last = 1'b1;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    cwnd_d       = cwnd_q;
    ss_d         = ss_q;
    dup_d        = dup_q;
    in_flight_d  = in_flight_q;
    last_acked_d = last_acked_q;
    last_sent_d  = last_sent_q;
    acked_d      = acked_q;
    total_d      = total_q;
    credit_d     = credit_q;
    active_d     = active_q;
    first_pend_d = first_pend_q;
    first_kind_d = first_kind_q;
    first_seq_d  = first_seq_q;
    burst_en_d   = burst_en_q;
    end_pend_d   = end_pend_q;

    if (cmd_i.update) begin
      first_pend_d = 1'b0;
      burst_en_d   = 1'b0;
      end_pend_d   = 1'b0;
      case (item_q.func)
        FN_START: begin
          total_d      = item_q.seg_count;
          acked_d      = '0;
          last_acked_d = '1;
          last_sent_d  = '0;
          dup_d        = '0;
          credit_d     = '0;
          cwnd_d       = win_t'(1);
          ss_d         = ss_new;
          phase_d      = (win_t'(1) >= ss_new) ? MODE_CA : MODE_SS;
          first_pend_d = 1'b1;
          first_seq_d  = '0;
          if (item_q.seg_count == '0) begin
            in_flight_d  = '0;
            active_d     = 1'b0;
            first_kind_d = KIND_END;
          end else begin
            in_flight_d  = win_t'(1);
            active_d     = 1'b1;
            first_kind_d = KIND_NEW;
          end
        end
        FN_ACK: begin
          if (active_q) begin
            if (a_plus > next_exp) begin
              // New cumulative ACK.
              acked_d      = acked_new;
              in_flight_d  = (ackpt_t'(in_flight_q) > diff) ?
                             (in_flight_q - diff[WIN_BITS-1:0]) : '0;
              last_acked_d = a_clip;
              if (last_sent_q < a_clip[SEQ_BITS-1:0]) last_sent_d = a_clip[SEQ_BITS-1:0];
              dup_d        = '0;
              burst_en_d   = 1'b1;
              end_pend_d   = (acked_new >= total_q);
              case (phase_q)
                MODE_SS: begin
                  cwnd_d = grown;
                  if (grown >= ss_q) begin
                    phase_d  = MODE_CA;
                    credit_d = '0;
                  end
                end
                MODE_CA: begin
                  if (credit_n >= cwnd_q) begin
                    cwnd_d   = grown;
                    credit_d = '0;
                  end else begin
                    credit_d = credit_n;
                  end
                end
                default: begin
                  // Fast recovery ends: the window deflates to the threshold.
                  cwnd_d   = ss_q;
                  phase_d  = MODE_CA;
                  credit_d = '0;
                end
              endcase
            end else if (a_plus == next_exp) begin
              if (phase_q == MODE_FR) begin
                cwnd_d     = grown;
                burst_en_d = 1'b1;
              end else begin
                dup_d = dup_n;
                if (dup_n == 2'd3) begin
                  ss_d         = half;
                  cwnd_d       = (ss_plus3 > (WIN_BITS+1)'(MAX_WINDOW)) ?
                                 WIN_MAX : ss_plus3[WIN_BITS-1:0];
                  phase_d      = MODE_FR;
                  last_sent_d  = next_exp[SEQ_BITS-1:0];
                  first_pend_d = 1'b1;
                  first_kind_d = KIND_RETX;
                  first_seq_d  = next_exp[SEQ_BITS-1:0];
                end
              end
            end
          end
        end
        FN_TIMEOUT: begin
          if (active_q) begin
            ss_d         = half;
            cwnd_d       = win_t'(1);
            dup_d        = '0;
            credit_d     = '0;
            phase_d      = (win_t'(1) >= half) ? MODE_CA : MODE_SS;
            last_sent_d  = next_exp[SEQ_BITS-1:0];
            first_pend_d = 1'b1;
            first_kind_d = KIND_RETX;
            first_seq_d  = next_exp[SEQ_BITS-1:0];
          end
        end
        default: begin
        end
      endcase
    end else if (cmd_i.emit) begin
      if (first_pend_q) begin
        first_pend_d = 1'b0;
      end else if (burst_ok) begin
        last_sent_d = ls_p1[SEQ_BITS-1:0];
        in_flight_d = inf_p1[WIN_BITS-1:0];
      end else if (end_pend_q) begin
        end_pend_d = 1'b0;
        active_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_ss_q    <= win_t'(8);
      phase_q      <= MODE_SS;
      cwnd_q       <= win_t'(1);
      ss_q         <= SSTHRESH_RESET;
      dup_q        <= '0;
      in_flight_q  <= '0;
      last_acked_q <= '1;
      last_sent_q  <= '0;
      acked_q      <= '0;
      total_q      <= '0;
      credit_q     <= '0;
      active_q     <= 1'b0;
      first_pend_q <= 1'b0;
      burst_en_q   <= 1'b0;
      end_pend_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) init_ss_q <= cfg_wdata_i;
      phase_q      <= phase_d;
      cwnd_q       <= cwnd_d;
      ss_q         <= ss_d;
      dup_q        <= dup_d;
      in_flight_q  <= in_flight_d;
      last_acked_q <= last_acked_d;
      last_sent_q  <= last_sent_d;
      acked_q      <= acked_d;
      total_q      <= total_d;
      credit_q     <= credit_d;
      active_q     <= active_d;
      first_pend_q <= first_pend_d;
      burst_en_q   <= burst_en_d;
      end_pend_q   <= end_pend_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) item_q <= in_data_i;
    first_kind_q <= first_kind_d;
    first_seq_q  <= first_seq_d;
    if (cmd_i.emit) out_q <= res_now;
  end

  assign st_o.out_free  = !out_valid_q || !out_stall_i;
  assign st_o.emit_last = res_now.last;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  // A new result must never overwrite one that is still waiting for its transfer.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  // Segments in flight never exceed the window limit.
  a_flight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_flight_q <= WIN_MAX)
    else $error("in-flight count above window limit");

  // A burst segment only goes out while the window has room.
  a_burst_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && !first_pend_q && burst_ok) |=> (in_flight_q <= cwnd_q))
    else $error("burst sent past the congestion window");

endmodule

// File: sv/reno_congestion_window_control.sv
// Reno congestion window control top level: controller and datapath.
// An accepted item passes the update state and then the send state, where its results are emitted.
// Throughput: one item gives N results (1 to 32), one result per cycle from the burst generator
// while the output is not stalled.
// A new item is accepted only after the previous item's last result has been loaded.
// Reset (rst_ni low, asynchronous) clears the window state and the threshold register to 8.
module reno_congestion_window_control import rcwc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  item_t in_data_i,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output res_t  out_data_o,
  input  logic  cfg_we_i,
  input  win_t  cfg_wdata_i
);

  cmd_t    cmd;
  status_t st;

  rcwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  rcwc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
